@@ sv/command_line_item_tokenizer_macros.svh @@
// ----------------------------------------------------------------------------
// Command-line item tokenizer: assertion macros
// Property wrappers that share one clock and one reset qualifier.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_ITEM_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_ITEM_TOKENIZER_MACROS_SVH

// Same-cycle implication on clk, off during rst.
`define CLIT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, off during rst.
`define CLIT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/clit_pkg.sv @@
// ----------------------------------------------------------------------------
// Command-line item tokenizer: package
// Result codes, error codes, character constants and the result entry type.
// ----------------------------------------------------------------------------
package clit_pkg;

  localparam logic [2:0] KIND_BYTE   = 3'd0;
  localparam logic [2:0] KIND_PLAIN  = 3'd1;
  localparam logic [2:0] KIND_QUOTED = 3'd2;
  localparam logic [2:0] KIND_EMPTY  = 3'd3;
  localparam logic [2:0] KIND_EQUALS = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;

  localparam logic [7:0] ERR_OVERFLOW = 8'd1;
  localparam logic [7:0] ERR_UNTERM   = 8'd2;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LC_E  = 8'h65;
  localparam logic [7:0] CH_UC_E  = 8'h45;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_UC_N  = 8'h4E;

  localparam logic [7:0] TOKEN_LIMIT_RESET = 8'd255;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tok;
    logic [7:0] len;
    logic       last;
  } result_t;

endpackage

@@ sv/command_line_item_tokenizer.sv @@
// ----------------------------------------------------------------------------
// Command-line item tokenizer
// Splits a character stream into command-line items, one character per
// request, giving token bytes, item ends and error codes.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser        | tlast
//  s_*     | in  | [7:0] char_in                 | -            | end_of_stream
//  m_*     | out | [7:0] token_byte,[15:8] length| [2:0] kind   | last_of_run
//  cfg_*   | in  | cfg_wdata = token_limit       | -            | -
//
//  One input request per cycle while s_tready is high; each gives zero,
//  one or two results. Results pass through a four-entry queue; s_tready
//  needs two free entries. Results leave one per cycle while m_tready is
//  high; each is registered in the queue before it reaches m_*.
//  rst clears mode, count, queue pointers and sets token_limit to 255.
// ----------------------------------------------------------------------------
`include "command_line_item_tokenizer_macros.svh"

module command_line_item_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] token_byte, [15:8] item_length
  output logic [2:0]  m_tuser,   // [2:0] result_kind
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    MODE_SKIP,
    MODE_PLAIN,
    MODE_QUOTE,
    MODE_STAR,
    MODE_DISCARD
  } mode_t;

  mode_t      mode, mode_next;
  logic [7:0] count, count_next;
  logic [7:0] token_limit;

  clit_pkg::result_t queue [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [FillW-1:0]  fill, fill_next;

  logic       in_acc, out_acc;
  logic [7:0] c;
  logic       eos;

  clit_pkg::result_t sk, acc, e0, e1;
  logic              sk_has;
  mode_t             sk_mode;
  logic [7:0]        sk_count;
  logic [7:0]        acc_byte;
  mode_t             acc_mode;
  logic [1:0]        n;

  assign c       = s_tdata;
  assign eos     = s_tlast;
  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // skip-blank evaluation of the current character
  always_comb begin
    sk       = '0;
    sk_has   = 1'b0;
    sk_mode  = MODE_SKIP;
    sk_count = '0;
    if (eos || c == clit_pkg::CH_LF || c == clit_pkg::CH_SEMI) begin
      sk_has  = 1'b1;
      sk.kind = clit_pkg::KIND_EMPTY;
    end else if (c == clit_pkg::CH_SPACE || c == clit_pkg::CH_TAB) begin
      sk_has = 1'b0;
    end else if (c == clit_pkg::CH_EQ) begin
      sk_has  = 1'b1;
      sk.kind = clit_pkg::KIND_EQUALS;
    end else if (c == clit_pkg::CH_QUOTE) begin
      sk_mode = MODE_QUOTE;
    end else if (token_limit == 8'd0) begin
      sk_has  = 1'b1;
      sk.kind = clit_pkg::KIND_ERROR;
      sk.tok  = clit_pkg::ERR_OVERFLOW;
      sk_mode = MODE_DISCARD;
    end else begin
      sk_has   = 1'b1;
      sk.kind  = clit_pkg::KIND_BYTE;
      sk.tok   = c;
      sk_mode  = MODE_PLAIN;
      sk_count = 8'd1;
    end
  end

  // byte accepted inside an item, with escape mapping after a star
  always_comb begin
    acc_byte = c;
    acc_mode = MODE_QUOTE;
    if (mode == MODE_STAR) begin
      if (c inside {clit_pkg::CH_LC_E, clit_pkg::CH_UC_E}) begin
        acc_byte = clit_pkg::CH_ESC;
      end else if (c inside {clit_pkg::CH_LC_N, clit_pkg::CH_UC_N}) begin
        acc_byte = clit_pkg::CH_LF;
      end
    end else if (mode == MODE_PLAIN) begin
      acc_mode = MODE_PLAIN;
    end
    acc = '0;
    if (count >= token_limit) begin
      acc.kind = clit_pkg::KIND_ERROR;
      acc.tok  = clit_pkg::ERR_OVERFLOW;
    end else begin
      acc.kind = clit_pkg::KIND_BYTE;
      acc.tok  = acc_byte;
    end
  end

  always_comb begin
    e0         = '0;
    e1         = '0;
    n          = 2'd0;
    mode_next  = mode;
    count_next = count;
    case (mode)
      MODE_PLAIN, MODE_QUOTE, MODE_STAR: begin
        if (mode == MODE_PLAIN && (eos || c == clit_pkg::CH_SPACE || c == clit_pkg::CH_TAB
            || c == clit_pkg::CH_SEMI || c == clit_pkg::CH_EQ || c == clit_pkg::CH_LF)) begin
          e0.kind    = clit_pkg::KIND_PLAIN;
          e0.len     = count;
          e1         = sk;
          n          = sk_has ? 2'd2 : 2'd1;
          mode_next  = sk_mode;
          count_next = sk_count;
        end else if ((mode == MODE_QUOTE && (eos || c == clit_pkg::CH_LF))
                     || (mode == MODE_STAR && eos)) begin
          e0.kind    = clit_pkg::KIND_ERROR;
          e0.tok     = clit_pkg::ERR_UNTERM;
          n          = 2'd1;
          mode_next  = MODE_SKIP;
          count_next = '0;
        end else if (mode == MODE_QUOTE && c == clit_pkg::CH_QUOTE) begin
          e0.kind    = clit_pkg::KIND_QUOTED;
          e0.len     = count;
          n          = 2'd1;
          mode_next  = MODE_SKIP;
          count_next = '0;
        end else if (mode == MODE_QUOTE && c == clit_pkg::CH_STAR) begin
          mode_next = MODE_STAR;
        end else begin
          e0 = acc;
          n  = 2'd1;
          if (acc.kind == clit_pkg::KIND_ERROR) begin
            mode_next  = MODE_DISCARD;
            count_next = '0;
          end else begin
            mode_next  = acc_mode;
            count_next = count + 8'd1;
          end
        end
      end
      MODE_DISCARD: begin
        if (eos || c == clit_pkg::CH_LF || c == clit_pkg::CH_SEMI) begin
          mode_next  = MODE_SKIP;
          count_next = '0;
        end
      end
      default: begin
        e0         = sk;
        n          = sk_has ? 2'd1 : 2'd0;
        mode_next  = sk_mode;
        count_next = sk_count;
      end
    endcase
    e0.last = (n == 2'd1);
    e1.last = 1'b1;
  end

  assign s_tready  = fill <= FillW'(Depth - 2);
  assign m_tvalid  = fill != '0;
  assign m_tuser   = queue[rd_ptr].kind;
  assign m_tdata   = {queue[rd_ptr].len, queue[rd_ptr].tok};
  assign m_tlast   = queue[rd_ptr].last;

  always_comb begin
    fill_next = fill;
    if (in_acc) begin
      fill_next = fill_next + FillW'(n);
    end
    if (out_acc) begin
      fill_next = fill_next - FillW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_SKIP;
      count       <= '0;
      token_limit <= clit_pkg::TOKEN_LIMIT_RESET;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      fill        <= '0;
    end else begin
      if (cfg_we) begin
        token_limit <= cfg_wdata;
      end
      if (in_acc) begin
        mode   <= mode_next;
        count  <= count_next;
        wr_ptr <= wr_ptr + PtrW'(n);
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && n != 2'd0) begin
      queue[wr_ptr] <= e0;
    end
    if (in_acc && n == 2'd2) begin
      queue[wr_ptr + PtrW'(1)] <= e1;
    end
  end

  `CLIT_ASSERT_NOW(a_fill_bound, 1'b1, fill <= FillW'(Depth), "queue overfilled")
  `CLIT_ASSERT_NOW(a_discard_count, mode == MODE_DISCARD, count == 8'd0, "count kept in discard")
  `CLIT_ASSERT_NOW(a_skip_count, mode == MODE_SKIP, count == 8'd0, "count kept while skipping")
  `CLIT_ASSERT_NEXT(a_push_two, in_acc && n == 2'd2 && !out_acc,
                    fill == $past(fill) + FillW'(2), "double push lost an entry")

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Command-line item tokenizer testbench
// Feeds character requests into the tokenizer and checks every result against
// a cycle-free model of the scanner. A short directed run covers escapes,
// quoting, delimiters, overflow and discarding. It is followed by random
// phases of words, quoted strings and separators under several token limits.
// Both sides stall at random, and once the result side holds off long enough
// for the block to back up its input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 200;
  localparam int SETTLE         = 8;

  typedef enum logic [2:0] {
    SCAN_SKIP, SCAN_PLAIN, SCAN_QUOTE, SCAN_STAR, SCAN_DISCARD
  } scan_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } char_req_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  char_req_t          char_queue[$];
  clit_pkg::result_t  pending_results[$];
  scan_t      scan_mode     = SCAN_SKIP;
  logic [7:0] byte_count    = '0;
  logic [7:0] token_limit   = clit_pkg::TOKEN_LIMIT_RESET;
  int         mismatch_count = 0;
  int         idle_cycles    = 0;
  int         hold_requests  = 0;
  int         holds_served   = 0;
  int         hold_left      = 0;
  int         ready_calm     = 0;
  int         gap_left       = 0;
  int         calm_left      = 0;

  always #1 clk = ~clk;

  command_line_item_tokenizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------- scanner

  function automatic bit ends_plain(logic [7:0] c);
    return c == clit_pkg::CH_SPACE || c == clit_pkg::CH_TAB || c == clit_pkg::CH_SEMI
        || c == clit_pkg::CH_EQ || c == clit_pkg::CH_LF;
  endfunction

  function automatic void add_result(logic [2:0] k, logic [7:0] t, logic [7:0] l);
    pending_results.push_back('{kind: k, tok: t, len: l, last: 1'b0});
  endfunction

  function automatic void take_byte(logic [7:0] b, scan_t next_mode);
    if (byte_count >= token_limit) begin
      add_result(clit_pkg::KIND_ERROR, clit_pkg::ERR_OVERFLOW, 8'd0);
      scan_mode  = SCAN_DISCARD;
      byte_count = '0;
    end else begin
      add_result(clit_pkg::KIND_BYTE, b, 8'd0);
      byte_count = byte_count + 8'd1;
      scan_mode  = next_mode;
    end
  endfunction

  function automatic void start_item(logic [7:0] c, logic eos);
    byte_count = '0;
    scan_mode  = SCAN_SKIP;
    if (eos || c == clit_pkg::CH_LF || c == clit_pkg::CH_SEMI) begin
      add_result(clit_pkg::KIND_EMPTY, 8'd0, 8'd0);
    end else if (c == clit_pkg::CH_EQ) begin
      add_result(clit_pkg::KIND_EQUALS, 8'd0, 8'd0);
    end else if (c == clit_pkg::CH_QUOTE) begin
      scan_mode = SCAN_QUOTE;
    end else if (c != clit_pkg::CH_SPACE && c != clit_pkg::CH_TAB) begin
      take_byte(c, SCAN_PLAIN);
    end
  endfunction

  function automatic void tokenize_char(logic [7:0] c, logic eos);
    int         first;
    logic [7:0] b;
    first = pending_results.size();
    case (scan_mode)
      SCAN_PLAIN: begin
        if (eos || ends_plain(c)) begin
          add_result(clit_pkg::KIND_PLAIN, 8'd0, byte_count);
          start_item(c, eos);
        end else begin
          take_byte(c, SCAN_PLAIN);
        end
      end
      SCAN_QUOTE: begin
        if (eos || c == clit_pkg::CH_LF) begin
          add_result(clit_pkg::KIND_ERROR, clit_pkg::ERR_UNTERM, 8'd0);
          scan_mode  = SCAN_SKIP;
          byte_count = '0;
        end else if (c == clit_pkg::CH_QUOTE) begin
          add_result(clit_pkg::KIND_QUOTED, 8'd0, byte_count);
          scan_mode  = SCAN_SKIP;
          byte_count = '0;
        end else if (c == clit_pkg::CH_STAR) begin
          scan_mode = SCAN_STAR;
        end else begin
          take_byte(c, SCAN_QUOTE);
        end
      end
      SCAN_STAR: begin
        if (eos) begin
          add_result(clit_pkg::KIND_ERROR, clit_pkg::ERR_UNTERM, 8'd0);
          scan_mode  = SCAN_SKIP;
          byte_count = '0;
        end else begin
          b = c;
          if (c == clit_pkg::CH_LC_E || c == clit_pkg::CH_UC_E) begin
            b = clit_pkg::CH_ESC;
          end else if (c == clit_pkg::CH_LC_N || c == clit_pkg::CH_UC_N) begin
            b = clit_pkg::CH_LF;
          end
          take_byte(b, SCAN_QUOTE);
        end
      end
      SCAN_DISCARD: begin
        if (eos || c == clit_pkg::CH_LF || c == clit_pkg::CH_SEMI) begin
          scan_mode  = SCAN_SKIP;
          byte_count = '0;
        end
      end
      default: begin
        start_item(c, eos);
      end
    endcase
    if (pending_results.size() > first) begin
      pending_results[pending_results.size() - 1].last = 1'b1;
    end
  endfunction

  // ------------------------------------------------------------ request side

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  always @(posedge clk) begin
    char_req_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) tokenize_char(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          s_tvalid <= 1'b0;
          gap_left--;
        end else if (char_queue.size() > 0) begin
          req = char_queue.pop_front();
          s_tdata  <= req.ch;
          s_tlast  <= req.eos;
          s_tvalid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------- result side

  always @(posedge clk) begin
    clit_pkg::result_t want;
    int                r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d tok=%h len=%0d last=%b",
                   $time, m_tuser, m_tdata[7:0], m_tdata[15:8], m_tlast);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_tuser !== want.kind || m_tdata[7:0] !== want.tok ||
              m_tdata[15:8] !== want.len || m_tlast !== want.last) begin
            $display("%0t: expected kind=%0d tok=%h len=%0d last=%b",
                     $time, want.kind, want.tok, want.len, want.last,
                     ", got kind=%0d tok=%h len=%0d last=%b",
                     m_tuser, m_tdata[7:0], m_tdata[15:8], m_tlast);
            mismatch_count++;
          end
        end
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
        m_tready <= 1'b0;
      end else if (ready_calm > 0) begin
        ready_calm--;
        m_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          hold_left = $urandom_range(8, 40);
        end else if (r < 5) begin
          ready_calm = $urandom_range(30, 80);
        end
        m_tready <= (r >= 20);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("command_line_item_tokenizer test failed");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void put_char(logic [7:0] c, logic eos);
    char_queue.push_back('{ch: c, eos: eos});
  endfunction

  function automatic void put_text(string s);
    foreach (s[i]) put_char(s[i], 1'b0);
  endfunction

  function automatic void put_word(int n);
    logic [7:0] c;
    repeat (n) begin
      do c = 8'($urandom_range(0, 255)); while (ends_plain(c) || c == clit_pkg::CH_QUOTE);
      put_char(c, 1'b0);
    end
  endfunction

  function automatic void put_quoted();
    logic [7:0] c;
    int         r;
    put_char(clit_pkg::CH_QUOTE, 1'b0);
    repeat ($urandom_range(0, 8)) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        put_char(clit_pkg::CH_STAR, 1'b0);
        case ($urandom_range(0, 4))
          0: put_char(clit_pkg::CH_LC_E, 1'b0);
          1: put_char(clit_pkg::CH_UC_E, 1'b0);
          2: put_char(clit_pkg::CH_LC_N, 1'b0);
          3: put_char(clit_pkg::CH_UC_N, 1'b0);
          default: put_char(8'($urandom_range(0, 255)), 1'b0);
        endcase
      end else begin
        do c = 8'($urandom_range(0, 255));
        while (c inside {clit_pkg::CH_QUOTE, clit_pkg::CH_LF, clit_pkg::CH_STAR});
        put_char(c, 1'b0);
      end
    end
    r = $urandom_range(0, 19);
    if (r == 0) begin
      put_char(clit_pkg::CH_LF, 1'b0);
    end else if (r == 1) begin
      put_char(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      put_char(clit_pkg::CH_QUOTE, 1'b0);
    end
  endfunction

  function automatic void put_separator();
    case ($urandom_range(0, 7))
      0, 1: put_char(clit_pkg::CH_SPACE, 1'b0);
      2: put_char(clit_pkg::CH_TAB, 1'b0);
      3: put_char(clit_pkg::CH_SEMI, 1'b0);
      4: put_char(clit_pkg::CH_EQ, 1'b0);
      5: put_char(clit_pkg::CH_LF, 1'b0);
      6: begin
        put_char(clit_pkg::CH_SPACE, 1'b0);
        put_char(clit_pkg::CH_TAB, 1'b0);
        put_char(clit_pkg::CH_SPACE, 1'b0);
      end
      default: put_char(8'($urandom_range(0, 255)), 1'b1);
    endcase
  endfunction

  function automatic void put_command_lines(int budget, bit long_words);
    int r;
    while (char_queue.size() < budget) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        if (long_words && $urandom_range(0, 15) == 0) begin
          put_word($urandom_range(240, 270));
        end else begin
          put_word($urandom_range(1, 8));
        end
      end else if (r < 60) begin
        put_quoted();
      end else if (r < 92) begin
        put_separator();
      end else begin
        put_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (char_queue.size() != 0 || s_tvalid || pending_results.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_token_limit(logic [7:0] v);
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    token_limit  = v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] limits [6];
    int         budgets[6];
    limits  = '{8'd255, 8'd1, 8'd0, 8'd7, 8'd0, 8'd255};
    budgets = '{250, 150, 100, 250, 250, 600};
    limits[4] = 8'($urandom_range(2, 16));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extremes of the byte range, delimiters, escapes, quoting at the reset limit
    put_char(8'h00, 1'b0);
    put_char(8'hFF, 1'b0);
    put_text(" ;=\n");
    put_text("\"*e*N**\"\"\"");
    put_text("\"q\n");
    put_text("\t\"*");
    put_char(8'($urandom_range(0, 255)), 1'b1);
    put_text("x=");
    put_char(8'($urandom_range(0, 255)), 1'b1);
    wait_drained();

    // overflow, then discard up to the semicolon
    set_token_limit(8'd2);
    put_text("abcd;z \n");
    wait_drained();

    // zero limit: every byte overflows, plain and quoted
    set_token_limit(8'd0);
    put_text("k\n\"k\n");
    wait_drained();

    foreach (limits[i]) begin
      set_token_limit(limits[i]);
      put_command_lines(budgets[i], i == 5);
      // hold off the result side while requests keep coming
      if (i == 0) hold_requests++;
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("command_line_item_tokenizer test passed");
    end else begin
      $display("command_line_item_tokenizer test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/clit_pkg.sv
sv/command_line_item_tokenizer.sv
tb/tb_top.sv
